/* rtl/core/rarmt_pkg.sv */
package rarmt_pkg;

    localparam int VAL_W    = 64;
    localparam int POS_IN_W = 10;
    localparam int CFG_W    = 11;

    localparam logic [CFG_W-1:0] NUM_LEAVES_RST = 11'd1024;
    localparam logic [VAL_W-1:0] VAL_MAX_POS    = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_VISIT,
        ST_VCHK,
        ST_PW1,
        ST_PW2,
        ST_PW3,
        ST_DESC,
        ST_RET,
        ST_RC,
        ST_DONE
    } eng_state_t;

    // Control from the front end into the tree engine.
    typedef struct packed {
        logic start;
        logic query;
        logic range_error;
        logic out_free;
    } eng_ctrl_t;

    // Status from the tree engine back to the front end.
    typedef struct packed {
        logic idle;
        logic done;
        logic range_error;
    } eng_stat_t;

endpackage

/* rtl/core/rarmt_if.sv */
interface rarmt_req_if
    import rarmt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                command;
    logic [POS_IN_W-1:0] range_low;
    logic [POS_IN_W-1:0] range_high;
    logic [VAL_W-1:0]    add_value;

    modport source (output valid, command, range_low, range_high, add_value, input ready);
    modport sink (input valid, command, range_low, range_high, add_value, output ready);
endinterface

interface rarmt_res_if
    import rarmt_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] min_value;
    logic             range_error;

    modport source (output valid, min_value, range_error, input ready);
    modport sink (input valid, min_value, range_error, output ready);
endinterface

interface rarmt_cfg_if
    import rarmt_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

/* rtl/core/rarmt_tree.sv */
module rarmt_tree
    import rarmt_pkg::*;
#(
    parameter int MAX_LEAVES = 1024
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  eng_ctrl_t                       ctrl,
    input  logic [$clog2(MAX_LEAVES)-1:0]   range_lo,
    input  logic [$clog2(MAX_LEAVES)-1:0]   range_hi,
    input  logic [VAL_W-1:0]                amount,
    output eng_stat_t                       stat,
    output logic [VAL_W-1:0]                min_value
);

    localparam int PW     = $clog2(MAX_LEAVES);
    localparam int NODE_W = PW + 1;
    localparam int NODES  = 2 ** NODE_W;
    localparam int STK_D  = NODE_W;
    localparam int SP_W   = $clog2(STK_D + 1);
    localparam int IDX_W  = $clog2(STK_D);
    localparam logic [PW-1:0]     POS_LAST = PW'(MAX_LEAVES - 1);
    localparam logic [NODE_W-1:0] ROOT     = NODE_W'(1);
    localparam logic [NODE_W-1:0] CLR_LAST = {NODE_W{1'b1}};

    eng_state_t state_reg, state_next;

    logic [NODE_W-1:0] node_reg, node_next;
    logic [PW-1:0]     lo_reg, lo_next, hi_reg, hi_next;
    logic [PW-1:0]     a_reg, a_next, b_reg, b_next;
    logic [VAL_W-1:0]  amt_reg, amt_next, acc_reg, acc_next, p_reg, p_next;
    logic              query_reg, query_next, err_reg, err_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [NODE_W-1:0] clr_reg, clr_next;

    logic [NODE_W-1:0] stk_node_reg [STK_D];
    logic [PW-1:0]     stk_lo_reg [STK_D];
    logic [PW-1:0]     stk_hi_reg [STK_D];
    logic              stk_second_reg [STK_D];

    logic              stk_we;
    logic [IDX_W-1:0]  stk_wi;
    logic [NODE_W-1:0] stk_w_node;
    logic [PW-1:0]     stk_w_lo, stk_w_hi;
    logic              stk_w_second;

    logic [VAL_W-1:0]  min_mem [NODES];
    logic [VAL_W-1:0]  pend_mem [NODES];
    logic              mem_re, we_min, we_pend;
    logic [NODE_W-1:0] ra0, ra1, wa;
    logic [VAL_W-1:0]  wd_min, wd_pend;
    logic [VAL_W-1:0]  rd0_min, rd1_min, rd0_pend, rd1_pend;

    logic [IDX_W-1:0]  top_idx;
    logic [PW-1:0]     a_c, b_c, mid, top_mid;
    logic [NODE_W-1:0] left_c, right_c, top_node;
    logic              full_cover, sp_zero, top_second;

    function automatic logic [VAL_W-1:0] smin(input logic [VAL_W-1:0] x,
                                             input logic [VAL_W-1:0] y);
        return ($signed(x) < $signed(y)) ? x : y;
    endfunction

    // Geometry of the current node and of the stack top.
    always_comb
    begin
        top_idx    = IDX_W'(sp_reg - SP_W'(1));
        a_c        = (a_reg > lo_reg) ? a_reg : lo_reg;
        b_c        = (b_reg < hi_reg) ? b_reg : hi_reg;
        mid        = PW'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
        left_c     = {node_reg[NODE_W-2:0], 1'b0};
        right_c    = {node_reg[NODE_W-2:0], 1'b1};
        full_cover = (lo_reg == a_c) && (hi_reg == b_c);
        sp_zero    = (sp_reg == '0);
        top_node   = stk_node_reg[top_idx];
        top_second = stk_second_reg[top_idx];
        top_mid    = PW'(({1'b0, stk_lo_reg[top_idx]} + {1'b0, stk_hi_reg[top_idx]}) >> 1);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = ctrl.range_error ? ST_DONE : ST_VISIT;
                end
            end
            ST_VISIT: state_next = ST_VCHK;
            ST_VCHK:
            begin
                if (full_cover)
                begin
                    state_next = ST_RET;
                end
                else if (rd0_pend != '0)
                begin
                    state_next = ST_PW1;
                end
                else
                begin
                    state_next = ST_DESC;
                end
            end
            ST_PW1:  state_next = ST_PW2;
            ST_PW2:  state_next = ST_PW3;
            ST_PW3:  state_next = ST_DESC;
            ST_DESC: state_next = ST_VISIT;
            ST_RET:
            begin
                if (sp_zero)
                begin
                    state_next = query_reg ? ST_DONE : ST_IDLE;
                end
                else if (top_second)
                begin
                    state_next = ST_VISIT;
                end
                else if (!query_reg)
                begin
                    state_next = ST_RC;
                end
                else
                begin
                    state_next = ST_RET;
                end
            end
            ST_RC: state_next = ST_RET;
            ST_DONE:
            begin
                if (ctrl.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        node_next    = node_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        amt_next     = amt_reg;
        acc_next     = acc_reg;
        p_next       = p_reg;
        query_next   = query_reg;
        err_next     = err_reg;
        sp_next      = sp_reg;
        clr_next     = clr_reg;
        stk_we       = 1'b0;
        stk_wi       = IDX_W'(sp_reg);
        stk_w_node   = node_reg;
        stk_w_lo     = lo_reg;
        stk_w_hi     = hi_reg;
        stk_w_second = 1'b0;
        mem_re       = 1'b0;
        we_min       = 1'b0;
        we_pend      = 1'b0;
        ra0          = node_reg;
        ra1          = right_c;
        wa           = node_reg;
        wd_min       = '0;
        wd_pend      = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                we_min   = 1'b1;
                we_pend  = 1'b1;
                wa       = clr_reg;
                clr_next = clr_reg + NODE_W'(1);
            end
            ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    query_next = ctrl.query;
                    err_next   = ctrl.range_error;
                    a_next     = range_lo;
                    b_next     = range_hi;
                    amt_next   = amount;
                    acc_next   = VAL_MAX_POS;
                    node_next  = ROOT;
                    lo_next    = '0;
                    hi_next    = POS_LAST;
                    sp_next    = '0;
                end
            end
            ST_VISIT:
            begin
                mem_re = 1'b1;
            end
            ST_VCHK:
            begin
                if (full_cover)
                begin
                    if (query_reg)
                    begin
                        acc_next = smin(acc_reg, rd0_min);
                    end
                    else
                    begin
                        we_min  = 1'b1;
                        we_pend = 1'b1;
                        wd_min  = rd0_min + amt_reg;
                        wd_pend = rd0_pend + amt_reg;
                    end
                end
                else if (rd0_pend != '0)
                begin
                    p_next = rd0_pend;
                    mem_re = 1'b1;
                    ra0    = left_c;
                    ra1    = right_c;
                end
            end
            ST_PW1:
            begin
                we_min  = 1'b1;
                we_pend = 1'b1;
                wa      = left_c;
                wd_min  = rd0_min + p_reg;
                wd_pend = rd0_pend + p_reg;
            end
            ST_PW2:
            begin
                we_min  = 1'b1;
                we_pend = 1'b1;
                wa      = right_c;
                wd_min  = rd1_min + p_reg;
                wd_pend = rd1_pend + p_reg;
            end
            ST_PW3:
            begin
                we_pend = 1'b1;
            end
            ST_DESC:
            begin
                stk_we       = 1'b1;
                stk_w_second = !(b_c <= mid) && !(a_c > mid);
                sp_next      = sp_reg + SP_W'(1);
                if (a_c > mid)
                begin
                    node_next = right_c;
                    lo_next   = mid + PW'(1);
                end
                else
                begin
                    node_next = left_c;
                    hi_next   = mid;
                end
            end
            ST_RET:
            begin
                if (!sp_zero)
                begin
                    if (top_second)
                    begin
                        // Left half done; the right half runs under the same frame.
                        stk_we       = 1'b1;
                        stk_wi       = top_idx;
                        stk_w_node   = top_node;
                        stk_w_lo     = stk_lo_reg[top_idx];
                        stk_w_hi     = stk_hi_reg[top_idx];
                        stk_w_second = 1'b0;
                        node_next    = {top_node[NODE_W-2:0], 1'b1};
                        lo_next      = top_mid + PW'(1);
                        hi_next      = stk_hi_reg[top_idx];
                    end
                    else
                    begin
                        sp_next   = sp_reg - SP_W'(1);
                        node_next = top_node;
                        if (!query_reg)
                        begin
                            mem_re = 1'b1;
                            ra0    = {top_node[NODE_W-2:0], 1'b0};
                            ra1    = {top_node[NODE_W-2:0], 1'b1};
                        end
                    end
                end
            end
            ST_RC:
            begin
                we_min = 1'b1;
                wd_min = smin(rd0_min, rd1_min);
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            sp_reg    <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg  <= node_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        amt_reg   <= amt_next;
        acc_reg   <= acc_next;
        p_reg     <= p_next;
        query_reg <= query_next;
        err_reg   <= err_next;
        if (stk_we)
        begin
            stk_node_reg[stk_wi]   <= stk_w_node;
            stk_lo_reg[stk_wi]     <= stk_w_lo;
            stk_hi_reg[stk_wi]     <= stk_w_hi;
            stk_second_reg[stk_wi] <= stk_w_second;
        end
    end

    // Node minimum and pending-add memories: one write port, two read ports.
    always_ff @(posedge clk)
    begin
        if (we_min)
        begin
            min_mem[wa] <= wd_min;
        end
        if (we_pend)
        begin
            pend_mem[wa] <= wd_pend;
        end
        if (mem_re)
        begin
            rd0_min  <= min_mem[ra0];
            rd1_min  <= min_mem[ra1];
            rd0_pend <= pend_mem[ra0];
            rd1_pend <= pend_mem[ra1];
        end
    end

    assign stat.idle        = (state_reg == ST_IDLE);
    assign stat.done        = (state_reg == ST_DONE) && ctrl.out_free;
    assign stat.range_error = err_reg;
    assign min_value        = err_reg ? '0 : acc_reg;

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STK_D))
        else $error("tree walk stack overflow");

    a_visit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_VISIT) |-> (node_reg != '0) && (lo_reg <= hi_reg))
        else $error("visited node has a bad span");

    a_error_skips_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && ctrl.start && ctrl.range_error) |=> (state_reg == ST_DONE))
        else $error("error request entered the tree walk");

    a_done_in_done: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |=> (state_reg == ST_IDLE) && (sp_reg == '0))
        else $error("result given with frames left on the stack");

endmodule

/* rtl/core/range_add_range_min_tree.sv */
// An out-of-range request skips the tree walk; its error result is given once the result
// register is free. A valid request walks the lazy tree node by node, up to about
// 4*log2(MAX_LEAVES) nodes; pending adds go down through the single node-memory write port.
// Throughput: one request at a time; the next is accepted once the engine is idle again.
// Reset: num_leaves returns to 1024 and a clearing pass zeroes all 2*2^clog2(MAX_LEAVES)
// entries (2048 by default) of both node memories before the first request is accepted.
module range_add_range_min_tree
    import rarmt_pkg::*;
#(
    parameter int MAX_LEAVES = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    rarmt_req_if.sink   req,
    rarmt_res_if.source res,
    rarmt_cfg_if.sink   cfg
);

    localparam int PW = $clog2(MAX_LEAVES);

    // Number of positions in use; it is only looked at when a request is
    // range checked, so a write never disturbs a walk in progress.
    logic [CFG_W-1:0] num_leaves_reg;

    // Result register: decouples the tree walk from the downstream consumer.
    logic             res_valid_reg;
    logic [VAL_W-1:0] res_min_reg;
    logic             res_err_reg;

    logic             req_fire;
    logic             req_bad;
    logic [31:0]      limit;
    eng_ctrl_t        ctrl;
    eng_stat_t        stat;
    logic [VAL_W-1:0] eng_min;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_leaves_reg <= NUM_LEAVES_RST;
        end
        else if (cfg.valid)
        begin
            num_leaves_reg <= cfg.data;
        end
    end

    // A request is range checked on entry. The usable limit is num_leaves
    // capped at the tree size; a bad request bypasses the walk entirely.
    always_comb
    begin
        limit = (32'(num_leaves_reg) > 32'(MAX_LEAVES)) ? 32'(MAX_LEAVES)
                                                         : 32'(num_leaves_reg);
        req_bad = (req.range_low > req.range_high) || (32'(req.range_high) >= limit);
    end

    assign req.ready = stat.idle;
    assign req_fire  = req.valid && req.ready;

    always_comb
    begin
        ctrl.start       = req_fire;
        ctrl.query       = (req.command == CMD_QUERY);
        ctrl.range_error = req_bad;
        ctrl.out_free    = !res_valid_reg || res.ready;
    end

    rarmt_tree #(
        .MAX_LEAVES (MAX_LEAVES)
    ) u_tree (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .range_lo  (PW'(req.range_low)),
        .range_hi  (PW'(req.range_high)),
        .amount    (req.add_value),
        .stat      (stat),
        .min_value (eng_min)
    );

    // The engine only reports done when the result register can take it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (stat.done)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.done)
        begin
            res_min_reg <= eng_min;
            res_err_reg <= stat.range_error;
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.min_value   = res_min_reg;
    assign res.range_error = res_err_reg;

    a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> (!res_valid_reg || res.ready))
        else $error("result register overwritten before it was taken");

    a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> !stat.idle)
        else $error("engine did not start on an accepted request");

    a_error_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_err_reg) |-> (res_min_reg == '0))
        else $error("error result carries a nonzero minimum");

endmodule
